FILE: hdl/size_class_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the size class block allocator
// Concurrent checks, clocked on the rising edge and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define SCBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and constants of the size class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

    localparam int NUM_CLASSES_DEF = 4;
    localparam int MAX_BLOCKS_DEF  = 256;

    // registers kept for every class the port can address
    localparam int CFG_CLASSES = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 9;
    localparam int CLASS_W = 2;
    localparam int SLOT_W  = 8;
    localparam int LEN_W   = 9;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    // reach of an 8-bit slot handle
    localparam int SLOT_REACH = 256;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_CLASS   = 2'd1,
        ST_EXHAUSTED  = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIZE0  = 3'd0,
        REG_SIZE1  = 3'd1,
        REG_SIZE2  = 3'd2,
        REG_SIZE3  = 3'd3,
        REG_COUNT0 = 3'd4,
        REG_COUNT1 = 3'd5,
        REG_COUNT2 = 3'd6,
        REG_COUNT3 = 3'd7
    } t_reg_idx;

endpackage

FILE: hdl/size_class_block_allocator.sv
// Timing: frees, watermark grants and failed requests are registered straight
//   from the accepted beat; a grant popped from a free list first reads the
//   next-link memory, then waits in S_POP until the result register is free.
// Throughput: one beat per cycle unless the result channel stalls or a pop is in S_POP.
// Reset: synchronous, clears configuration, list heads, lengths, watermarks and
//   control; the link memory is not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Segregated fixed-size block pool: per-class free lists linked through a
// single synchronous link memory, plus a never-issued watermark per class.
// ----------------------------------------------------------------------------
module size_class_block_allocator #(
    parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF,
    parameter int MAX_BLOCKS  = scba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [scba_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [scba_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_mode,
    input  logic [scba_pkg::SIZE_W-1:0]         i_request_size,
    input  logic [scba_pkg::CLASS_W-1:0]        i_free_class,
    input  logic [scba_pkg::SLOT_W-1:0]         i_free_slot,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output scba_pkg::t_status                   o_status,
    output logic [scba_pkg::CLASS_W-1:0]        o_grant_class,
    output logic [scba_pkg::SLOT_W-1:0]         o_grant_slot
);
    import scba_pkg::*;

    localparam int CW         = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int LINK_DEPTH = NUM_CLASSES * MAX_BLOCKS;
    localparam int LAW        = $clog2(LINK_DEPTH);
    localparam int LIMIT      = (MAX_BLOCKS < SLOT_REACH) ? MAX_BLOCKS : SLOT_REACH;
    localparam logic [COUNT_W-1:0] LIMIT_C = COUNT_W'(LIMIT);

    typedef enum logic {S_IDLE, S_POP} t_state;

    function automatic logic [COUNT_W-1:0] usable(input logic [COUNT_W-1:0] cnt);
        return (cnt > LIMIT_C) ? LIMIT_C : cnt;
    endfunction

    function automatic logic [LAW-1:0] link_addr(input logic [CW-1:0] cls,
                                                 input logic [SLOT_W-1:0] slot);
        return LAW'(cls) * LAW'(MAX_BLOCKS) + LAW'(slot);
    endfunction

    // configuration
    logic [SIZE_W-1:0]  r_size  [CFG_CLASSES];
    logic [COUNT_W-1:0] r_count [CFG_CLASSES];

    // per-class list state
    logic [SLOT_W-1:0]  r_head  [NUM_CLASSES];
    logic [LEN_W-1:0]   r_len   [NUM_CLASSES];
    logic [COUNT_W-1:0] r_wmark [NUM_CLASSES];

    t_state             r_state;
    logic [CW-1:0]      r_cls;
    logic               r_out_valid;
    t_status            r_status;
    logic [CLASS_W-1:0] r_gclass;
    logic [SLOT_W-1:0]  r_gslot;

    // link memory
    logic [SLOT_W-1:0]  mem_link [LINK_DEPTH];
    logic [SLOT_W-1:0]  r_rdata;
    logic               mem_we;
    logic               mem_re;
    logic [LAW-1:0]     mem_addr;
    logic [SLOT_W-1:0]  mem_wdata;

    logic               out_free;
    logic               in_accept;
    logic               found;
    logic [CW-1:0]      mcls;
    logic [CW-1:0]      fcls;
    logic               free_ok;
    logic [COUNT_W-1:0] m_usable;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // lowest-numbered class with an exact size match wins
    always_comb begin
        found = 1'b0;
        mcls  = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (r_size[c] == i_request_size) begin
                found = 1'b1;
                mcls  = CW'(c);
            end
        end
    end

    assign fcls     = i_free_class[CW-1:0];
    assign free_ok  = ({1'b0, i_free_class} < 3'(NUM_CLASSES)) &&
                      ({1'b0, i_free_slot} < usable(r_count[2'(fcls)]));
    assign m_usable = usable(r_count[2'(mcls)]);

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = link_addr(fcls, i_free_slot);
        mem_wdata = r_head[fcls];
        if (in_accept) begin
            if (i_mode == MODE_FREE) begin
                mem_we = free_ok;
            end else if (found && r_len[mcls] != '0) begin
                mem_re   = 1'b1;
                mem_addr = link_addr(mcls, r_head[mcls]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_link[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem_link[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CFG_CLASSES; c++) begin
                r_size[c]  <= '0;
                r_count[c] <= '0;
            end
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= '0;
                r_len[c]   <= '0;
                r_wmark[c] <= '0;
            end
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cls       <= '0;
            r_status    <= ST_OK;
            r_gclass    <= '0;
            r_gslot     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_SIZE0:  r_size[0]  <= i_cfg_wdata;
                    REG_SIZE1:  r_size[1]  <= i_cfg_wdata;
                    REG_SIZE2:  r_size[2]  <= i_cfg_wdata;
                    REG_SIZE3:  r_size[3]  <= i_cfg_wdata;
                    REG_COUNT0: r_count[0] <= i_cfg_wdata[COUNT_W-1:0];
                    REG_COUNT1: r_count[1] <= i_cfg_wdata[COUNT_W-1:0];
                    REG_COUNT2: r_count[2] <= i_cfg_wdata[COUNT_W-1:0];
                    REG_COUNT3: r_count[3] <= i_cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_gclass <= '0;
                        r_gslot  <= '0;
                        if (i_mode == MODE_FREE) begin
                            r_out_valid <= 1'b1;
                            if (free_ok) begin
                                r_status     <= ST_OK;
                                r_head[fcls] <= i_free_slot;
                                if (r_len[fcls] != LEN_MAX) begin
                                    r_len[fcls] <= r_len[fcls] + LEN_W'(1);
                                end
                            end else begin
                                r_status <= ST_BAD_HANDLE;
                            end
                        end else if (!found) begin
                            r_out_valid <= 1'b1;
                            r_status    <= ST_NO_CLASS;
                        end else if (r_len[mcls] != '0) begin
                            // wait for the link of the head slot
                            r_cls   <= mcls;
                            r_state <= S_POP;
                        end else if (r_wmark[mcls] < m_usable) begin
                            r_out_valid   <= 1'b1;
                            r_status      <= ST_OK;
                            r_gclass      <= CLASS_W'(mcls);
                            r_gslot       <= r_wmark[mcls][SLOT_W-1:0];
                            r_wmark[mcls] <= r_wmark[mcls] + COUNT_W'(1);
                        end else begin
                            r_out_valid <= 1'b1;
                            r_status    <= ST_EXHAUSTED;
                        end
                    end
                end
                S_POP: begin
                    // hold until the result register can take the beat
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_status      <= ST_OK;
                        r_gclass      <= CLASS_W'(r_cls);
                        r_gslot       <= r_head[r_cls];
                        r_head[r_cls] <= r_rdata;
                        r_len[r_cls]  <= r_len[r_cls] - LEN_W'(1);
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_grant_class = r_gclass;
    assign o_grant_slot  = r_gslot;

`include "size_class_block_allocator_assert.svh"

    `SCBA_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, r_state == S_POP, r_len[r_cls] != '0, "pop from an empty free list")
    `SCBA_ASSERT_NOW(a_wmark_limit, i_clk, i_rst_n, 1'b1, r_wmark[0] <= LIMIT_C, "watermark beyond slot limit")
    `SCBA_ASSERT_NOW(a_fail_no_grant, i_clk, i_rst_n, r_out_valid && r_status != ST_OK, r_gclass == '0 && r_gslot == '0, "failed result carries a grant")
    `SCBA_ASSERT_NEXT(a_pop_stalls_input, i_clk, i_rst_n, in_accept && mem_re, o_in_stall, "input taken during list pop")

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Size class block allocator testbench
// Drives allocate and free beats through the request channel, predicts every
// result from a shadow copy of the class registers, free lists and
// watermarks, and checks each result beat in order. A short directed table
// covers reset, extremes and status codes; random phases with fresh class
// settings, a double-free storm and a long output hold-off follow.
// ----------------------------------------------------------------------------
module testbench;
    import scba_pkg::*;

    localparam int NUM_CLASSES      = NUM_CLASSES_DEF;
    localparam int MAX_BLOCKS       = MAX_BLOCKS_DEF;
    localparam int PHASES           = 10;
    localparam int PHASE_BEATS      = 75;
    localparam int PRESSURE_PHASE   = 1;
    localparam int STORM_PHASE      = 6;
    localparam int STORM_CLASS      = 1;
    localparam int STORM_FREES      = 530;
    localparam int STORM_BEATS      = 560;
    localparam int CHOKE_CYCLES     = 300;
    localparam int FIRST_CONFIGURED = 4;
    localparam int MAX_GAP          = 11;
    localparam int MAX_SHOWN        = 10;
    localparam int CYCLE_LIMIT      = 250000;

    typedef struct packed {
        logic               mode;
        logic [SIZE_W-1:0]  req_size;
        logic [CLASS_W-1:0] fclass;
        logic [SLOT_W-1:0]  fslot;
    } t_beat;

    typedef struct packed {
        t_status            status;
        logic [CLASS_W-1:0] gclass;
        logic [SLOT_W-1:0]  gslot;
    } t_grant;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [SLOT_W-1:0]  slot;
    } t_handle;

    typedef struct {
        t_beat   b;
        bit      typed;
        t_status status;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata    = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  i_mode         = MODE_ALLOC;
    logic [SIZE_W-1:0]     i_request_size = '0;
    logic [CLASS_W-1:0]    i_free_class   = '0;
    logic [SLOT_W-1:0]     i_free_slot    = '0;
    logic                  i_out_stall    = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_status               o_status;
    logic [CLASS_W-1:0]    o_grant_class;
    logic [SLOT_W-1:0]     o_grant_slot;

    // shadow of the block
    logic [SIZE_W-1:0]  cls_size  [CFG_CLASSES];
    logic [COUNT_W-1:0] cls_count [CFG_CLASSES];
    logic [SLOT_W-1:0]  head      [NUM_CLASSES];
    logic [LEN_W-1:0]   flen      [NUM_CLASSES];
    logic [COUNT_W-1:0] wmark     [NUM_CLASSES];
    logic [SLOT_W-1:0]  link      [NUM_CLASSES][MAX_BLOCKS];

    logic [SIZE_W-1:0]  plan_size  [CFG_CLASSES];
    logic [COUNT_W-1:0] plan_count [CFG_CLASSES];

    t_grant  grants_due[$];
    t_handle live[$];
    t_row    plan[$];

    int   errors         = 0;
    int   beats_sent     = 0;
    int   beats_checked  = 0;
    int   blocks_granted = 0;
    int   cycles         = 0;
    int   free_pct       = 40;
    bit   calm           = 1'b0;
    bit   choke_req      = 1'b0;
    logic choke          = 1'b0;

    size_class_block_allocator #(
        .NUM_CLASSES(NUM_CLASSES),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_request_size(i_request_size),
        .i_free_class  (i_free_class),
        .i_free_slot   (i_free_slot),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_grant_class (o_grant_class),
        .o_grant_slot  (o_grant_slot)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int usable(int c);
        int n;
        n = int'(cls_count[c]);
        if (n > MAX_BLOCKS) n = MAX_BLOCKS;
        if (n > SLOT_REACH) n = SLOT_REACH;
        return n;
    endfunction

    function automatic t_grant predict_grant(t_beat b);
        t_grant  g;
        t_handle h;
        int      c;
        int      hit;
        g.status = ST_OK;
        g.gclass = '0;
        g.gslot  = '0;
        hit      = -1;
        if (b.mode == MODE_ALLOC) begin
            // lowest matching class only; later classes are never tried
            for (c = 0; c < NUM_CLASSES; c++)
                if (hit < 0 && cls_size[c] == b.req_size) hit = c;
            if (hit < 0) begin
                g.status = ST_NO_CLASS;
            end else if (flen[hit] != 0) begin
                g.gclass  = CLASS_W'(hit);
                g.gslot   = head[hit];
                head[hit] = link[hit][head[hit]];
                flen[hit] = flen[hit] - 1'b1;
            end else if (wmark[hit] < usable(hit)) begin
                g.gclass   = CLASS_W'(hit);
                g.gslot    = SLOT_W'(wmark[hit]);
                wmark[hit] = wmark[hit] + 1'b1;
            end else begin
                g.status = ST_EXHAUSTED;
            end
            if (hit >= 0 && g.status == ST_OK) begin
                h.cls  = g.gclass;
                h.slot = g.gslot;
                live.push_back(h);
                blocks_granted++;
            end
        end else begin
            c = int'(b.fclass);
            if (c >= NUM_CLASSES || b.fslot >= usable(c)) begin
                g.status = ST_BAD_HANDLE;
            end else begin
                link[c][b.fslot] = head[c];
                head[c] = b.fslot;
                // saturate under repeated double frees, head still moves
                if (flen[c] != LEN_MAX) flen[c] = flen[c] + 1'b1;
            end
        end
        return g;
    endfunction

    function automatic t_beat random_beat();
        t_beat b;
        int    k;
        int    c;
        b.mode     = ($urandom_range(0, 99) < free_pct) ? MODE_FREE : MODE_ALLOC;
        b.req_size = SIZE_W'($urandom);
        b.fclass   = CLASS_W'($urandom);
        b.fslot    = SLOT_W'($urandom);
        if (b.mode == MODE_ALLOC) begin
            if ($urandom_range(0, 9) < 8)
                b.req_size = cls_size[$urandom_range(0, CFG_CLASSES-1)];
        end else begin
            k = $urandom_range(0, 9);
            if (k < 6 && live.size() > 0) begin
                // hand back a block that was granted earlier
                k        = $urandom_range(0, live.size()-1);
                b.fclass = live[k].cls;
                b.fslot  = live[k].slot;
                live.delete(k);
            end else if (k < 9) begin
                c = int'(b.fclass);
                if (usable(c) > 0) b.fslot = SLOT_W'($urandom_range(0, usable(c)-1));
            end
        end
        return b;
    endfunction

    function automatic void draw_classes();
        int c;
        for (c = 0; c < CFG_CLASSES; c++) begin
            case ($urandom_range(0, 5)) inside
                0:       plan_size[c] = '0;
                1:       plan_size[c] = '1;
                [2:3]:   plan_size[c] = SIZE_W'($urandom_range(1, 4) * 16);
                default: plan_size[c] = SIZE_W'($urandom);
            endcase
            case ($urandom_range(0, 7)) inside
                0:       plan_count[c] = '0;
                1:       plan_count[c] = 9'd1;
                [2:4]:   plan_count[c] = COUNT_W'($urandom_range(2, 8));
                5:       plan_count[c] = 9'd256;
                6:       plan_count[c] = COUNT_W'($urandom_range(257, 511));
                default: plan_count[c] = COUNT_W'($urandom_range(9, 255));
            endcase
        end
    endfunction

    function automatic t_row row(logic mode, logic [SIZE_W-1:0] sz, int fc, int fs,
                                 bit typed, t_status st);
        t_row r;
        r.b.mode     = mode;
        r.b.req_size = sz;
        r.b.fclass   = CLASS_W'(fc);
        r.b.fslot    = SLOT_W'(fs);
        r.typed      = typed;
        r.status     = st;
        return r;
    endfunction

    function automatic void flag_mismatch(string what, t_grant want);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("%0t %s: expected status %0d class %0d slot %0d, got %0d %0d %0d",
                     $time, what, want.status, want.gclass, want.gslot,
                     o_status, o_grant_class, o_grant_slot);
    endfunction

    // wait until every result is home, then leave the block a little slack
    task automatic settle();
        i_in_valid <= 1'b0;
        while (grants_due.size() > 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic program_classes();
        int c;
        for (c = 0; c < CFG_CLASSES; c++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_idx   <= CFG_IDX_W'(REG_SIZE0 + c);
            i_cfg_wdata <= plan_size[c];
            @(posedge i_clk);
        end
        for (c = 0; c < CFG_CLASSES; c++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_idx   <= CFG_IDX_W'(REG_COUNT0 + c);
            // junk above the count field must be dropped
            i_cfg_wdata <= {(CFG_DATA_W-COUNT_W)'($urandom), plan_count[c]};
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        cls_size  = plan_size;
        cls_count = plan_count;
    endtask

    task automatic send_beat(t_beat b, bit typed, t_status fixed_status);
        int     gap;
        t_grant g;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= b.mode;
        i_request_size <= b.req_size;
        i_free_class   <= b.fclass;
        i_free_slot    <= b.fslot;
        do @(posedge i_clk); while (o_in_stall);
        g = predict_grant(b);
        if (typed) begin
            g.status = fixed_status;
            g.gclass = '0;
            g.gslot  = '0;
        end
        grants_due.push_back(g);
        beats_sent++;
    endtask

    initial begin : request_side
        int    i;
        int    p;
        int    n;
        t_beat b;
        for (i = 0; i < CFG_CLASSES; i++) begin
            cls_size[i]  = '0;
            cls_count[i] = '0;
        end
        for (i = 0; i < NUM_CLASSES; i++) begin
            head[i]  = '0;
            flen[i]  = '0;
            wmark[i] = '0;
            for (n = 0; n < MAX_BLOCKS; n++) link[i][n] = '0;
        end

        // straight after reset every size is zero and every count is zero
        plan.push_back(row(MODE_ALLOC, 16'h0000, 0,   0, 1, ST_EXHAUSTED));
        plan.push_back(row(MODE_ALLOC, 16'hFFFF, 0,   0, 1, ST_NO_CLASS));
        plan.push_back(row(MODE_FREE,  16'h0000, 0,   0, 1, ST_BAD_HANDLE));
        plan.push_back(row(MODE_FREE,  16'hFFFF, 3, 255, 1, ST_BAD_HANDLE));
        // slot zero of every class is freed first, so every link read later
        // lands on an entry that has been written
        plan.push_back(row(MODE_FREE,  16'h0000, 0,   0, 1, ST_OK));
        plan.push_back(row(MODE_FREE,  16'h0000, 1,   0, 1, ST_OK));
        plan.push_back(row(MODE_FREE,  16'h0000, 2,   0, 1, ST_OK));
        plan.push_back(row(MODE_FREE,  16'h0000, 3,   0, 1, ST_OK));
        plan.push_back(row(MODE_ALLOC, 16'd64,   0,   0, 0, ST_OK));
        plan.push_back(row(MODE_ALLOC, 16'd64,   0,   0, 0, ST_OK));
        plan.push_back(row(MODE_ALLOC, 16'd64,   0,   0, 0, ST_OK));
        plan.push_back(row(MODE_ALLOC, 16'd64,   0,   0, 0, ST_OK));
        plan.push_back(row(MODE_ALLOC, 16'hFFFF, 0,   0, 0, ST_OK));
        plan.push_back(row(MODE_ALLOC, 16'hFFFF, 0,   0, 0, ST_OK));
        plan.push_back(row(MODE_ALLOC, 16'hFFFF, 0,   0, 0, ST_OK));
        plan.push_back(row(MODE_FREE,  16'h0000, 0,   2, 1, ST_BAD_HANDLE));
        plan.push_back(row(MODE_FREE,  16'h0000, 3, 255, 1, ST_OK));
        plan.push_back(row(MODE_ALLOC, 16'h0000, 3, 255, 0, ST_OK));
        plan.push_back(row(MODE_FREE,  16'h0000, 1,   0, 1, ST_OK));
        plan.push_back(row(MODE_FREE,  16'h0000, 1,   0, 1, ST_OK));
        plan.push_back(row(MODE_ALLOC, 16'hFFFF, 0,   0, 0, ST_OK));
        plan.push_back(row(MODE_ALLOC, 16'hFFFF, 0,   0, 0, ST_OK));
        plan.push_back(row(MODE_ALLOC, 16'hFFFF, 0,   0, 0, ST_OK));
        plan.push_back(row(MODE_ALLOC, 16'd1234,  0,   0, 1, ST_NO_CLASS));
        plan.push_back(row(MODE_FREE,  16'h0000, 2,   4, 1, ST_OK));
        plan.push_back(row(MODE_FREE,  16'h0000, 2,   5, 1, ST_BAD_HANDLE));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < plan.size(); i++) begin
            if (i == FIRST_CONFIGURED) begin
                settle();
                // class two is shadowed by class zero; class three count
                // overshoots the slot reach
                plan_size  = '{16'd64, 16'hFFFF, 16'd64, 16'd0};
                plan_count = '{9'd2, 9'd1, 9'd5, 9'd511};
                program_classes();
            end
            send_beat(plan[i].b, plan[i].typed, plan[i].status);
        end

        for (p = 0; p < PHASES; p++) begin
            settle();
            if (p == STORM_PHASE) begin
                plan_size  = '{16'd100, 16'd200, 16'd300, 16'd400};
                plan_count = '{9'd4, 9'd2, 9'd8, 9'd256};
            end else begin
                draw_classes();
            end
            program_classes();
            calm     = (p == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
            free_pct = $urandom_range(25, 60);
            if (p == PRESSURE_PHASE) choke_req = 1'b1;
            n = (p == STORM_PHASE) ? STORM_BEATS : PHASE_BEATS;
            for (i = 0; i < n; i++) begin
                if (p == STORM_PHASE) begin
                    // pile double frees onto one class until its length saturates
                    b.req_size = SIZE_W'($urandom);
                    b.fclass   = CLASS_W'($urandom);
                    b.fslot    = SLOT_W'($urandom);
                    if (i < STORM_FREES) begin
                        b.mode   = MODE_FREE;
                        b.fclass = CLASS_W'(STORM_CLASS);
                        b.fslot  = SLOT_W'($urandom_range(0, 1));
                    end else begin
                        b.mode     = MODE_ALLOC;
                        b.req_size = cls_size[STORM_CLASS];
                    end
                end else begin
                    b = random_beat();
                end
                send_beat(b, 1'b0, ST_OK);
            end
        end

        settle();
        repeat (6) @(posedge i_clk);
        $display("covered %0d request beats over %0d class settings, %0d blocks granted",
                 beats_sent, PHASES + 1, blocks_granted);
        $display("checked %0d result beats, %0d mismatches", beats_checked, errors);
        if (errors == 0) begin
            $display("size_class_block_allocator: match");
        end else begin
            $display("size_class_block_allocator: mismatch");
        end
        $finish;
    end

    initial begin : result_side
        t_grant want;
        int     hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                beats_checked++;
                if (grants_due.size() == 0) begin
                    want = '0;
                    flag_mismatch("result beat with nothing outstanding", want);
                end else begin
                    want = grants_due.pop_front();
                    if (o_status !== want.status || o_grant_class !== want.gclass ||
                        o_grant_slot !== want.gslot)
                        flag_mismatch("result beat differs", want);
                end
                hold = calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            i_out_stall <= choke || (hold > 0);
            if (hold > 0) hold--;
        end
    end

    // hold the result channel off for a long stretch so the block backs up
    initial begin : choke_side
        wait (choke_req);
        @(posedge i_clk);
        choke <= 1'b1;
        repeat (CHOKE_CYCLES) @(posedge i_clk);
        choke <= 1'b0;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("size_class_block_allocator: mismatch");
        $finish;
    end

endmodule
